// ----- src/gbn_pkg.sv -----
// Shared types and constants for the Go-Back-N sender window block.
// Used by the window core and the top level.
`timescale 1ns / 1ps

package gbn_pkg;

  localparam int SEQ_SPACE_DEF = 20;
  localparam int CFG_DW        = 8;

  localparam logic [7:0] TOTAL_PACKETS_RST = 8'd5;
  localparam logic [4:0] WINDOW_SIZE_RST   = 5'd4;
  localparam logic [7:0] TIMEOUT_LIMIT_RST = 8'd20;

  typedef enum logic [1:0] {
    CFG_TOTAL_PACKETS = 2'd0,
    CFG_WINDOW_SIZE   = 2'd1,
    CFG_TIMEOUT_LIMIT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] total_packets;
    logic [4:0] window_size;
    logic [7:0] timeout_limit;
  } cfg_t;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_code;
    logic [7:0] packet_index;
    logic       timed_out;
    logic       ack_rejected;
    logic       finished;
  } result_t;

endpackage

// ----- src/gbn_in_if.sv -----
// Input channel of the Go-Back-N sender window: one polling round per item.
// Standalone valid/ready interface; no package dependency.
`timescale 1ns / 1ps

interface gbn_in_if;
  logic       valid;
  logic       ready;
  logic       ack_valid;
  logic [7:0] ack_byte;

  modport source (output valid, output ack_valid, output ack_byte, input ready);
  modport sink (input valid, input ack_valid, input ack_byte, output ready);
endinterface

// ----- src/gbn_out_if.sv -----
// Result channel of the Go-Back-N sender window: one result item per round.
// Standalone valid/ready interface; no package dependency.
`timescale 1ns / 1ps

interface gbn_out_if;
  logic       valid;
  logic       ready;
  logic       send_valid;
  logic [7:0] send_code;
  logic [7:0] packet_index;
  logic       timed_out;
  logic       ack_rejected;
  logic       finished;

  modport source (output valid, output send_valid, output send_code, output packet_index,
                  output timed_out, output ack_rejected, output finished, input ready);
  modport sink (input valid, input send_valid, input send_code, input packet_index,
                input timed_out, input ack_rejected, input finished, output ready);
endinterface

// ----- src/gbn_core.sv -----
// Window state and per-round update logic of the Go-Back-N sender.
// Depends on gbn_pkg for the configuration and result structs.
`timescale 1ns / 1ps

module gbn_core import gbn_pkg::*; #(
  parameter int SEQ_SPACE = SEQ_SPACE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic       ack_valid,
  input  logic [7:0] ack_byte,
  input  cfg_t       cfg,
  output result_t    res
);

  localparam int SEQ_W = (SEQ_SPACE > 2) ? $clog2(SEQ_SPACE) : 1;

  logic [SEQ_SPACE-1:0] slot_free_r, slot_free_nxt;
  logic [SEQ_W-1:0]     next_seq_r, next_seq_nxt;
  logic [SEQ_W-1:0]     base_seq_r, base_seq_nxt;
  logic [7:0]           sent_count_r, sent_count_nxt;
  logic [7:0]           idle_rounds_r, idle_rounds_nxt;
  logic                 done_r, done_nxt;

  logic [SEQ_W-1:0]     win_dist, ack_dist, outstanding, ack_seq, seq_inc, ack_inc;
  logic [7:0]           ack_idx, sent_after;
  logic [8:0]           idle_inc;
  logic                 do_send, ack_ok, do_timeout;

  function automatic logic [SEQ_W-1:0] ring_dist(logic [SEQ_W-1:0] from, logic [SEQ_W-1:0] to);
    logic [SEQ_W:0] d;
    if (to >= from) begin
      d = {1'b0, to} - {1'b0, from};
    end else begin
      d = {1'b0, to} + (SEQ_W+1)'(SEQ_SPACE) - {1'b0, from};
    end
    return d[SEQ_W-1:0];
  endfunction

  function automatic logic [SEQ_W-1:0] seq_plus1(logic [SEQ_W-1:0] s);
    logic [SEQ_W:0] t;
    t = {1'b0, s} + (SEQ_W+1)'(1);
    return (t == (SEQ_W+1)'(SEQ_SPACE)) ? '0 : t[SEQ_W-1:0];
  endfunction

  always_comb begin
    win_dist   = ring_dist(base_seq_r, next_seq_r);
    do_send    = !done_r && (8'(win_dist) < {3'b0, cfg.window_size}) &&
                 slot_free_r[next_seq_r] && (sent_count_r < cfg.total_packets);
    seq_inc    = seq_plus1(next_seq_r);
    sent_after = do_send ? sent_count_r + 8'd1 : sent_count_r;

    ack_idx    = ack_byte - 8'd1;
    ack_ok     = ack_valid && (ack_idx < 8'(SEQ_SPACE));
    ack_seq    = ack_idx[SEQ_W-1:0];
    ack_dist   = ring_dist(base_seq_r, ack_seq);
    ack_inc    = seq_plus1(ack_seq);

    idle_inc   = {1'b0, idle_rounds_r} + 9'd1;
    do_timeout = !done_r && !ack_valid && (idle_inc > {1'b0, cfg.timeout_limit});
    outstanding = ring_dist(base_seq_r, do_send ? seq_inc : next_seq_r);

    slot_free_nxt   = slot_free_r;
    next_seq_nxt    = do_send ? seq_inc : next_seq_r;
    base_seq_nxt    = base_seq_r;
    sent_count_nxt  = sent_after;
    idle_rounds_nxt = idle_rounds_r;
    done_nxt        = done_r;

    for (int j = 0; j < SEQ_SPACE; j++) begin
      if (do_send && (next_seq_r == SEQ_W'(j))) begin
        slot_free_nxt[j] = 1'b0;
      end
      if (!done_r && ack_ok && (ring_dist(base_seq_r, SEQ_W'(j)) <= ack_dist)) begin
        slot_free_nxt[j] = 1'b1;
      end
      if (do_timeout &&
          (8'(ring_dist(base_seq_r, SEQ_W'(j))) < {3'b0, cfg.window_size})) begin
        slot_free_nxt[j] = 1'b1;
      end
    end

    if (!done_r) begin
      if (ack_valid) begin
        if (ack_ok) begin
          base_seq_nxt = ack_inc;
        end
        idle_rounds_nxt = '0;
        if ((sent_after >= cfg.total_packets) && (ack_byte == cfg.total_packets)) begin
          done_nxt = 1'b1;
        end
      end else if (do_timeout) begin
        sent_count_nxt  = (sent_after >= 8'(outstanding)) ? sent_after - 8'(outstanding) : '0;
        next_seq_nxt    = base_seq_r;
        idle_rounds_nxt = '0;
      end else begin
        idle_rounds_nxt = idle_inc[7:0];
      end
    end

    res.send_valid   = do_send;
    res.send_code    = do_send ? 8'(next_seq_r) + 8'd1 : '0;
    res.packet_index = do_send ? sent_count_r : '0;
    res.timed_out    = do_timeout;
    res.ack_rejected = !done_r && ack_valid && !ack_ok;
    res.finished     = done_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_free_r   <= '1;
      next_seq_r    <= '0;
      base_seq_r    <= '0;
      sent_count_r  <= '0;
      idle_rounds_r <= '0;
      done_r        <= 1'b0;
    end else if (step) begin
      slot_free_r   <= slot_free_nxt;
      next_seq_r    <= next_seq_nxt;
      base_seq_r    <= base_seq_nxt;
      sent_count_r  <= sent_count_nxt;
      idle_rounds_r <= idle_rounds_nxt;
      done_r        <= done_nxt;
    end
  end

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> done_r)
    else $error("finished flag dropped without reset");

  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (step && done_r) |-> (!res.send_valid && !res.timed_out && !res.ack_rejected))
    else $error("activity after the transfer completed");

  a_seq_range: assert property (@(posedge clk) disable iff (!rst_n)
    (next_seq_r < SEQ_W'(SEQ_SPACE - 1) || next_seq_r == SEQ_W'(SEQ_SPACE - 1)) &&
    (base_seq_r < SEQ_W'(SEQ_SPACE - 1) || base_seq_r == SEQ_W'(SEQ_SPACE - 1)))
    else $error("sequence pointer outside the sequence space");

  a_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.timed_out) |=> (next_seq_r == $past(base_seq_r)))
    else $error("timeout did not rewind to the window base");

  a_send_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.send_valid && !res.timed_out) |=> (sent_count_r == $past(sent_count_r) + 8'd1))
    else $error("send did not advance the packet count");

endmodule

// ----- src/go_back_n_sender_window_top.sv -----
// Go-Back-N sender window: input register, window core, result register.
// A round is held in the input register; its core result is then held in the result register.
// Throughput: one round per cycle while the result side is not stalled; the core updates all state per round.
// Reset (synchronous, rst_n low) restores configuration defaults, frees every slot and
// clears the pointers, counters and finished flag. Depends on gbn_pkg, gbn_in_if,
// gbn_out_if and gbn_core.
`timescale 1ns / 1ps

module go_back_n_sender_window_top import gbn_pkg::*; #(
  parameter int SEQ_SPACE = SEQ_SPACE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  gbn_in_if.sink            in_if,
  gbn_out_if.source         out_if,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_idx,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  cfg_t       cfg_r;
  logic       in_v_r;
  logic       in_ack_valid_r;
  logic [7:0] in_ack_byte_r;
  logic       out_v_r;
  result_t    out_res_r;
  result_t    core_res;
  logic       advance, step;

  assign advance     = !out_v_r || out_if.ready;
  assign step        = in_v_r && advance;
  assign in_if.ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.total_packets <= TOTAL_PACKETS_RST;
      cfg_r.window_size   <= WINDOW_SIZE_RST;
      cfg_r.timeout_limit <= TIMEOUT_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_TOTAL_PACKETS: cfg_r.total_packets <= cfg_wdata[7:0];
        CFG_WINDOW_SIZE:   cfg_r.window_size   <= cfg_wdata[4:0];
        CFG_TIMEOUT_LIMIT: cfg_r.timeout_limit <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_if.ready) begin
        in_v_r <= in_if.valid;
      end
      if (advance) begin
        out_v_r <= in_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_ack_valid_r <= in_if.ack_valid;
      in_ack_byte_r  <= in_if.ack_byte;
    end
    if (step) begin
      out_res_r <= core_res;
    end
  end

  gbn_core #(
    .SEQ_SPACE (SEQ_SPACE)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .ack_valid (in_ack_valid_r),
    .ack_byte  (in_ack_byte_r),
    .cfg       (cfg_r),
    .res       (core_res)
  );

  assign out_if.valid        = out_v_r;
  assign out_if.send_valid   = out_res_r.send_valid;
  assign out_if.send_code    = out_res_r.send_code;
  assign out_if.packet_index = out_res_r.packet_index;
  assign out_if.timed_out    = out_res_r.timed_out;
  assign out_if.ack_rejected = out_res_r.ack_rejected;
  assign out_if.finished     = out_res_r.finished;

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_if.ready) |=> (out_v_r && $stable(out_res_r)))
    else $error("stalled result was overwritten");

  a_step_fills: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_v_r)
    else $error("processed round produced no result");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !advance) |=> (in_v_r && $stable(in_ack_byte_r) && $stable(in_ack_valid_r)))
    else $error("buffered round lost while the result side stalled");

endmodule
